@@ rtl/bpbm_pkg.sv @@
// Shared types and constants for the BGRA packer and box mipmap block.
package bpbm_pkg;
    localparam int MAX_WIDTH = 2048;
    localparam int MAX_LEVELS = 13;
    localparam logic [7:0] ALPHA_LIMIT = 8'hf8;
    localparam logic [1:0] REG_NUM_COMPONENTS = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    // Level 0 pixel handed from the front part to the back part.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
        logic       low_alpha;
    } t_pix;

    // Result bundle: level, coordinates, BGRA bytes, sticky flag, last.
    typedef struct packed {
        logic [3:0]  level;
        logic [10:0] x;
        logic [10:0] y;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [7:0]  alpha;
        logic        alpha_found;
        logic        last;
    } t_res;
endpackage

@@ rtl/bpbm_front.sv @@
// Front part: accept input pixels, pack to BGRA and classify alpha, two-entry queue.
module bpbm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [2:0]          i_num_components,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [63:0]         i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output bpbm_pkg::t_pix      o_pix
);
    bpbm_pkg::t_pix r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    bpbm_pkg::t_pix w_pix;
    logic [15:0] c0, c1, c2, c3;
    logic [2:0] nc;
    logic push, pop;

    always_comb begin
        c0 = i_data[15:0];
        c1 = i_data[31:16];
        c2 = i_data[47:32];
        c3 = i_data[63:48];
        nc = i_num_components;
        if (nc == 3'd0) nc = 3'd1;
        if (nc > 3'd4) nc = 3'd4;
        w_pix.red = c0[7:0];
        w_pix.green = (nc >= 3'd3) ? c1[7:0] : c0[7:0];
        w_pix.blue = (nc >= 3'd3) ? c2[7:0] : c0[7:0];
        w_pix.alpha = 8'hff;
        w_pix.low_alpha = 1'b0;
        if (nc == 3'd2) begin
            w_pix.alpha = c1[7:0];
            w_pix.low_alpha = c1 < {8'd0, bpbm_pkg::ALPHA_LIMIT};
        end else if (nc == 3'd4) begin
            w_pix.alpha = c3[7:0];
            w_pix.low_alpha = c3 < {8'd0, bpbm_pkg::ALPHA_LIMIT};
        end
    end

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_pix = r_q[r_rp];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) r_q[r_wp] <= w_pix;
    end
endmodule

@@ rtl/bpbm_back.sv @@
// Back part: level positions, line buffer and 2x2 box cascade, one level per step.
module bpbm_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clear,
    input  logic [11:0]         i_width,
    input  logic [11:0]         i_height,
    input  logic                i_valid,
    output logic                o_ready,
    input  bpbm_pkg::t_pix      i_pix,
    output logic                o_valid,
    input  logic                i_ready,
    output bpbm_pkg::t_res      o_res
);
    localparam int AW = $clog2(bpbm_pkg::MAX_WIDTH);
    localparam int LW = (bpbm_pkg::MAX_LEVELS > 1) ? $clog2(bpbm_pkg::MAX_LEVELS) : 1;

    typedef enum logic [2:0] {S_IDLE, S_L0, S_FETCH, S_LEVEL, S_OUT, S_EMIT} t_state;
    t_state r_state, r_after;

    logic [35:0] r_mem [bpbm_pkg::MAX_WIDTH];
    logic [35:0] r_rd;
    logic [35:0] r_hold [bpbm_pkg::MAX_LEVELS];
    logic [10:0] r_col [bpbm_pkg::MAX_LEVELS];
    logic [10:0] r_row [bpbm_pkg::MAX_LEVELS];
    logic        r_seen;
    logic [3:0]  r_k;
    logic [3:0]  r_nlev;
    logic [11:0] r_cx, r_cy;
    logic [35:0] r_px;
    logic [AW-1:0] r_idx;
    logic        r_ovf;
    bpbm_pkg::t_res r_res;
    logic        r_ov;

    logic [11:0] w, h, m;
    logic [11:0] lw, lh;
    logic [LW-1:0] ki;
    logic [12:0] off;
    logic [12:0] idxw;
    logic [35:0] sum;
    logic [35:0] avg;
    logic [3:0] nlev;

    always_comb begin
        w = (i_width == 12'd0) ? 12'd1 : i_width;
        if (w > 12'(bpbm_pkg::MAX_WIDTH)) w = 12'(bpbm_pkg::MAX_WIDTH);
        h = (i_height == 12'd0) ? 12'd1 : i_height;
        if (h > 12'd2048) h = 12'd2048;
        m = (w < h) ? w : h;
        nlev = 4'd1;
        for (int i = 1; i < 12; i++) begin
            if ((m >> i) != 12'd0 && i < bpbm_pkg::MAX_LEVELS) nlev = 4'(i + 1);
        end
        ki = LW'(r_k);
        lw = w >> r_k;
        lh = h >> r_k;
        off = 13'(bpbm_pkg::MAX_WIDTH) - (13'(bpbm_pkg::MAX_WIDTH) >> (r_k - 4'd1));
        idxw = off + {2'd0, r_cx[11:1]};
        sum = r_hold[ki] + r_px;
        for (int i = 0; i < 4; i++) begin
            logic [9:0] t;
            t = {1'b0, sum[9*i +: 9]} + {1'b0, r_rd[9*i +: 9]};
            avg[9*i +: 9] = {1'b0, t[9:2]};
        end
    end

    assign o_ready = (r_state == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov <= 1'b0;
            r_seen <= 1'b0;
            for (int i = 0; i < bpbm_pkg::MAX_LEVELS; i++) begin
                r_col[i] <= '0;
                r_row[i] <= '0;
            end
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            if (i_clear) begin
                r_seen <= 1'b0;
                for (int i = 0; i < bpbm_pkg::MAX_LEVELS; i++) begin
                    r_col[i] <= '0;
                    r_row[i] <= '0;
                end
            end
            case (r_state)
                S_IDLE: if (i_valid && !r_ov) begin
                    logic cl;
                    cl = r_col[0] == 11'd0 && r_row[0] == 11'd0;
                    if (cl) begin
                        for (int i = 1; i < bpbm_pkg::MAX_LEVELS; i++) begin
                            r_col[i] <= '0;
                            r_row[i] <= '0;
                        end
                    end
                    r_seen <= (cl ? 1'b0 : r_seen) | i_pix.low_alpha;
                    r_px <= {1'b0, i_pix.alpha, 1'b0, i_pix.red,
                             1'b0, i_pix.green, 1'b0, i_pix.blue};
                    r_cx <= {1'b0, r_col[0]};
                    r_cy <= {1'b0, r_row[0]};
                    r_nlev <= nlev;
                    r_k <= 4'd1;
                    r_state <= S_L0;
                end
                S_L0: begin
                    r_res.level <= 4'd0;
                    r_res.x <= r_cx[10:0];
                    r_res.y <= r_cy[10:0];
                    r_res.blue <= r_px[7:0];
                    r_res.green <= r_px[16:9];
                    r_res.red <= r_px[25:18];
                    r_res.alpha <= r_px[34:27];
                    r_res.alpha_found <= r_seen;
                    if ({1'b0, r_col[0]} + 12'd1 >= w) begin
                        r_col[0] <= '0;
                        r_row[0] <= ({1'b0, r_row[0]} + 12'd1 >= h) ? 11'd0
                                                                   : r_row[0] + 11'd1;
                    end else begin
                        r_col[0] <= r_col[0] + 11'd1;
                    end
                    r_after <= S_FETCH;
                    r_state <= S_OUT;
                end
                S_FETCH: begin
                    logic stop;
                    stop = r_k >= r_nlev || r_cx >= {lw[10:0], 1'b0}
                        || r_cy >= {lh[10:0], 1'b0};
                    r_idx <= idxw[AW-1:0];
                    r_ovf <= idxw >= 13'(bpbm_pkg::MAX_WIDTH);
                    r_rd <= r_mem[idxw[AW-1:0]];
                    if (stop) begin
                        r_res.last <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (!r_cx[0]) begin
                        r_hold[ki] <= r_px;
                        r_res.last <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_LEVEL;
                    end
                    if (stop || !r_cx[0]) r_ov <= 1'b1;
                end
                S_LEVEL: begin
                    if (r_ovf) begin
                        r_res.last <= 1'b1;
                        r_ov <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (!r_cy[0]) begin
                        r_mem[r_idx] <= sum;
                        r_res.last <= 1'b1;
                        r_ov <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_res.last <= 1'b0;
                        r_ov <= 1'b1;
                        r_after <= S_EMIT;
                        r_state <= S_OUT;
                    end
                end
                S_EMIT: begin
                    r_res.level <= r_k;
                    r_res.x <= r_col[ki];
                    r_res.y <= r_row[ki];
                    r_res.blue <= avg[7:0];
                    r_res.green <= avg[16:9];
                    r_res.red <= avg[25:18];
                    r_res.alpha <= avg[34:27];
                    r_res.alpha_found <= r_seen;
                    r_px <= avg;
                    r_cx <= {1'b0, r_col[ki]};
                    r_cy <= {1'b0, r_row[ki]};
                    if ({1'b0, r_col[ki]} + 12'd1 >= lw) begin
                        r_col[ki] <= '0;
                        r_row[ki] <= ({1'b0, r_row[ki]} + 12'd1 >= lh) ? 11'd0
                                                                     : r_row[ki] + 11'd1;
                    end else begin
                        r_col[ki] <= r_col[ki] + 11'd1;
                    end
                    r_k <= r_k + 4'd1;
                    r_state <= S_FETCH;
                end
                S_OUT: if (!r_ov) begin
                    // hold until the pending result transfers
                    r_state <= r_after;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ rtl/bgra_pack_and_box_mipmap.sv @@
// Top level: BGRA packer with streaming 2x2 box mip chain.
// Each result is presented from S_FETCH or S_LEVEL, and each mip result is formed
// in S_EMIT once the result before it has transferred. A new pixel is taken only
// in S_IDLE with no result pending, so it waits until the sequential level walk
// for the pixel before ends, also when that walk ends on a line-buffer write.
// Reset (synchronous, active low): registers to 4 components, 2048 x 2048,
// positions and sticky alpha cleared; line buffer left unwritten.
module bgra_pack_and_box_mipmap (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // comp_first, comp_second, comp_third, comp_fourth
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // out_x, out_y, blue, green, red, alpha, alpha_found
    output logic [3:0]  m_axis_tuser,  // mip_level
    output logic        m_axis_tlast
);
    logic [2:0]  r_nc;
    logic [11:0] r_w, r_h;
    logic        w_clear;
    logic        f_valid, f_ready;
    bpbm_pkg::t_pix f_pix;
    bpbm_pkg::t_res res;

    assign w_clear = i_cfg_we && (i_cfg_index == bpbm_pkg::REG_NUM_COMPONENTS
        || i_cfg_index == bpbm_pkg::REG_IMAGE_WIDTH
        || i_cfg_index == bpbm_pkg::REG_IMAGE_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc <= 3'd4;
            r_w <= 12'd2048;
            r_h <= 12'd2048;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bpbm_pkg::REG_NUM_COMPONENTS: r_nc <= i_cfg_data[2:0];
                bpbm_pkg::REG_IMAGE_WIDTH: r_w <= i_cfg_data;
                bpbm_pkg::REG_IMAGE_HEIGHT: r_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bpbm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_num_components(r_nc),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_data(s_axis_tdata),
        .o_valid(f_valid), .i_ready(f_ready), .o_pix(f_pix)
    );

    bpbm_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clear(w_clear),
        .i_width(r_w), .i_height(r_h),
        .i_valid(f_valid), .o_ready(f_ready), .i_pix(f_pix),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {9'd0, res.alpha_found, res.alpha, res.red, res.green,
                           res.blue, res.y, res.x};
    assign m_axis_tuser = res.level;
    assign m_axis_tlast = res.last;

`ifndef SYNTHESIS
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> res.level < 4'(bpbm_pkg::MAX_LEVELS))
        else $error("mip level out of range");
    a_level0_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && res.level == 4'd0) |-> {1'b0, res.x} < r_w || r_w == 12'd0)
        else $error("level 0 column beyond width");
`endif
endmodule
